// ----- src/ctu_pkg.sv -----
// ctu_pkg: widths, time constants and status codes for the clock to utc fit
// used by the channel interfaces and the fit top level; no dependencies
`timescale 1ns / 1ps
package ctu_pkg;
  localparam int FRAC_BITS       = 20;
  localparam int SYS_W           = 42;
  localparam int TOW_W           = 40;
  localparam int WEEK_W          = 16;
  localparam int UTC_W           = 56;
  localparam int SOFF_W          = SYS_W + 1;
  localparam int UOFF_W          = UTC_W + 1;
  localparam int SLOPE_W         = 48;
  localparam int ICPT_W          = 60;
  localparam int STAT_W          = 2;
  localparam int SLOPE_FRAC      = 40;
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int CHUNK_W         = 16;
  localparam int CHUNK_N         = 3;

  // one gps week and the gps to unix epoch offset, in 2^-FRAC_BITS s units
  localparam logic [UTC_W-1:0] WEEK_UNITS  = UTC_W'(64'd604800 << FRAC_BITS);
  localparam logic [UTC_W-1:0] EPOCH_UNITS = UTC_W'(64'd315964800 << FRAC_BITS);

  typedef enum logic [STAT_W-1:0] {
    FIT_OK       = 2'd0,
    FIT_FEW      = 2'd1,
    FIT_ZERO_VAR = 2'd2,
    FIT_TRUNC    = 2'd3
  } fit_status_t;
endpackage

// ----- src/ctu_ifs.sv -----
// ctu_sample_if and ctu_fit_if: valid/ready channels for samples and fit results
// depends on ctu_pkg for the field widths
`timescale 1ns / 1ps
interface ctu_sample_if;
  logic                         valid;
  logic                         ready;
  logic [ctu_pkg::SYS_W-1:0]    system_time;
  logic [ctu_pkg::TOW_W-1:0]    tow_seconds;
  logic [ctu_pkg::WEEK_W-1:0]   week_number;
  logic                         last_sample;
  modport source (output valid, system_time, tow_seconds, week_number, last_sample,
                  input ready);
  modport sink (input valid, system_time, tow_seconds, week_number, last_sample,
                output ready);
endinterface

interface ctu_fit_if;
  logic                                valid;
  logic                                ready;
  logic signed [ctu_pkg::SLOPE_W-1:0]  slope;
  logic signed [ctu_pkg::ICPT_W-1:0]   intercept;
  logic [ctu_pkg::STAT_W-1:0]          fit_status;
  modport source (output valid, slope, intercept, fit_status, input ready);
  modport sink (input valid, slope, intercept, fit_status, output ready);
endinterface

// ----- src/ctu_ram.sv -----
// ctu_ram: simple dual port ram, one write port, one read port, registered read
// no dependencies
`timescale 1ns / 1ps
module ctu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/clock_to_utc_linear_fit.sv -----
// clock_to_utc_linear_fit: least squares fit of unix utc against local time
// depends on ctu_pkg, ctu_sample_if / ctu_fit_if and ctu_ram
//
//   channel   dir  beat contents
//   samples   in   system_time, tow_seconds, week_number, last_sample
//   fits      out  slope, intercept, fit_status (one beat per last_sample beat)
//
// a sample beat is taken and written to the sample ram if it has room
// a last_sample beat starts the fit over the stored samples; with DW the
// divider width (142 + count bits), the fit is a summing pass, two mean
// divisions of DW bits, a pass per sample through the 16 bit chunk
// multipliers, one slope division and the intercept multiply
// samples are not taken during a fit; a stalled result holds in the output
// register while the next set is collected
// synchronous reset clears control state only, the sample ram is not cleared
`timescale 1ns / 1ps
module clock_to_utc_linear_fit #(
  parameter int MAX_SAMPLES = ctu_pkg::MAX_SAMPLES_DEF
) (
  input logic          clk,
  input logic          rst,
  ctu_sample_if.sink   samples,
  ctu_fit_if.source    fits
);
  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int AW     = $clog2(MAX_SAMPLES);
  localparam int SOFF_W = ctu_pkg::SOFF_W;
  localparam int UOFF_W = ctu_pkg::UOFF_W;
  localparam int SUMS_W = SOFF_W + CW;
  localparam int SUMU_W = UOFF_W + CW;
  localparam int MS_W   = SOFF_W + 1;
  localparam int MU_W   = UOFF_W + 1;
  localparam int VAR_W  = 2 * SOFF_W + CW;
  localparam int COV_W  = SOFF_W + UOFF_W + CW + 1;
  localparam int DW     = COV_W + ctu_pkg::SLOPE_FRAC + 1;
  localparam int DCW    = $clog2(DW + 1);
  localparam int MA_W   = UOFF_W;
  localparam int MB_W   = ctu_pkg::CHUNK_W * ctu_pkg::CHUNK_N;
  localparam int MK_W   = $clog2(ctu_pkg::CHUNK_N + 1);
  localparam int T_W    = MS_W + 1;
  localparam int TERM_W = ctu_pkg::SLOPE_W + T_W;
  localparam int B_W    = ctu_pkg::ICPT_W + 4;
  localparam int SL_W   = ctu_pkg::SLOPE_W;

  localparam logic signed [B_W-1:0] ICPT_MAX = (B_W'(1) <<< (ctu_pkg::ICPT_W - 1)) - B_W'(1);
  localparam logic signed [B_W-1:0] ICPT_MIN = -(B_W'(1) <<< (ctu_pkg::ICPT_W - 1));

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SUM   = 11'b00000000010,
    S_DIV   = 11'b00000000100,
    S_RD    = 11'b00000001000,
    S_SUB   = 11'b00000010000,
    S_MUL   = 11'b00000100000,
    S_VCHK  = 11'b00001000000,
    S_SLOPE = 11'b00010000000,
    S_TSET  = 11'b00100000000,
    S_ICPT  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_MEAN_S = 2'd0,
    PH_MEAN_U = 2'd1,
    PH_SLOPE  = 2'd2
  } phase_t;

  state_t state;
  phase_t phase;

  logic [CW-1:0]                count;
  logic                         dropped;
  logic [ctu_pkg::SYS_W-1:0]    sys_ref;
  logic [ctu_pkg::UTC_W-1:0]    utc_ref;
  logic [CW-1:0]                n_fit;
  logic                         drop_fit;
  logic [CW-1:0]                idx;
  logic                         pend;

  logic signed [SUMS_W-1:0]     sum_s;
  logic signed [SUMU_W-1:0]     sum_u;
  logic signed [MS_W-1:0]       mean_s;
  logic signed [MU_W-1:0]       mean_u;
  logic [VAR_W-1:0]             var_acc;
  logic signed [COV_W-1:0]      cov_acc;
  logic [TERM_W-1:0]            term_acc;

  logic [DW-1:0]                dv_num;
  logic [DW-1:0]                dv_den;
  logic [DW-1:0]                dv_rem;
  logic [DW-1:0]                dv_q;
  logic [DCW-1:0]               dv_cnt;
  logic                         dv_neg;

  logic [SOFF_W-1:0]            s_mag;
  logic [MA_W-1:0]              mul_a;
  logic [MB_W-1:0]              mul_b;
  logic                         p_neg;
  logic                         mterm;
  logic [MK_W-1:0]              mk;
  logic [SOFF_W+ctu_pkg::CHUNK_W-1:0] prod_ss;
  logic [MA_W+ctu_pkg::CHUNK_W-1:0]   prod_au;

  logic signed [SL_W-1:0]           res_slope;
  logic signed [ctu_pkg::ICPT_W-1:0] res_icpt;
  ctu_pkg::fit_status_t             res_status;

  logic                             ovalid;
  logic signed [SL_W-1:0]           o_slope;
  logic signed [ctu_pkg::ICPT_W-1:0] o_icpt;
  ctu_pkg::fit_status_t             o_status;

  // input side
  logic                          acc_in;
  logic                          first;
  logic                          room;
  logic [CW-1:0]                 cnt_new;
  logic [ctu_pkg::UTC_W-1:0]     utc_now;
  logic [ctu_pkg::SYS_W-1:0]     sref;
  logic [ctu_pkg::UTC_W-1:0]     uref;
  logic [SOFF_W-1:0]             soff;
  logic [UOFF_W-1:0]             uoff;

  // ram
  logic                          ram_we;
  logic [AW-1:0]                 ram_raddr;
  logic [SOFF_W+UOFF_W-1:0]      ram_rdata;
  logic signed [SOFF_W-1:0]      rd_s;
  logic signed [UOFF_W-1:0]      rd_u;

  // datapath helpers
  logic [SUMS_W-1:0]             sums_mag;
  logic [SUMU_W-1:0]             sumu_mag;
  logic [COV_W-1:0]              cov_mag;
  logic [DW-1:0]                 rem_sh;
  logic                          dv_ge;
  logic [DW-1:0]                 q_signed;
  logic signed [SOFF_W+1:0]      ds;
  logic signed [UOFF_W+1:0]      du;
  logic [SOFF_W+1:0]             ds_mag;
  logic [UOFF_W+1:0]             du_mag;
  logic [ctu_pkg::CHUNK_W-1:0]   chunk;
  logic [MK_W-1:0]               sh;
  logic signed [SL_W-1:0]        slope_sat;
  logic [DW-1:0]                 slope_lim;
  logic signed [T_W-1:0]         tsum;
  logic [T_W-1:0]                tsum_mag;
  logic [SL_W-1:0]               slope_mag;
  logic [TERM_W-1:0]             term_rnd;
  logic signed [B_W-1:0]         term_q;
  logic signed [B_W-1:0]         b_full;

  assign acc_in   = samples.valid && samples.ready;
  assign first    = (count == '0);
  assign room     = (count < CW'(MAX_SAMPLES));
  assign cnt_new  = room ? count + CW'(1) : count;
  assign utc_now  = ctu_pkg::UTC_W'(samples.week_number) * ctu_pkg::WEEK_UNITS
                  + ctu_pkg::UTC_W'(samples.tow_seconds) + ctu_pkg::EPOCH_UNITS;
  assign sref     = first ? samples.system_time : sys_ref;
  assign uref     = first ? utc_now : utc_ref;
  assign soff     = SOFF_W'(samples.system_time) - SOFF_W'(sref);
  assign uoff     = UOFF_W'(utc_now) - UOFF_W'(uref);

  assign samples.ready = (state == S_IDLE);
  assign ram_we        = acc_in && room;
  assign ram_raddr     = idx[AW-1:0];
  assign rd_s          = ram_rdata[SOFF_W+UOFF_W-1:UOFF_W];
  assign rd_u          = ram_rdata[UOFF_W-1:0];

  ctu_ram #(
    .WIDTH (SOFF_W + UOFF_W),
    .DEPTH (MAX_SAMPLES)
  ) u_samples (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({soff, uoff}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sums_mag = sum_s[SUMS_W-1] ? SUMS_W'(-sum_s) : SUMS_W'(sum_s);
  assign sumu_mag = sum_u[SUMU_W-1] ? SUMU_W'(-sum_u) : SUMU_W'(sum_u);
  assign cov_mag  = cov_acc[COV_W-1] ? COV_W'(-cov_acc) : COV_W'(cov_acc);

  // restoring divider, one quotient bit per cycle
  assign rem_sh   = {dv_rem[DW-2:0], dv_num[DW-1]};
  assign dv_ge    = (rem_sh >= dv_den);
  assign q_signed = dv_neg ? -dv_q : dv_q;

  assign ds     = (SOFF_W + 2)'(rd_s) - (SOFF_W + 2)'(mean_s);
  assign du     = (UOFF_W + 2)'(rd_u) - (UOFF_W + 2)'(mean_u);
  assign ds_mag = ds[SOFF_W+1] ? -ds : ds;
  assign du_mag = du[UOFF_W+1] ? -du : du;

  assign chunk = ctu_pkg::CHUNK_W'(mul_b >> (ctu_pkg::CHUNK_W * mk));
  assign sh    = mk - MK_W'(1);

  // slope saturation to the 48 bit range
  assign slope_lim = DW'(1) << (SL_W - 1);
  always_comb begin
    if (!dv_neg) begin
      slope_sat = (dv_q >= slope_lim) ? SL_W'(slope_lim - DW'(1)) : SL_W'(dv_q);
    end else begin
      slope_sat = (dv_q > slope_lim) ? SL_W'(slope_lim) : -SL_W'(dv_q);
    end
  end

  assign tsum      = T_W'($signed({1'b0, sys_ref})) + T_W'(mean_s);
  assign tsum_mag  = tsum[T_W-1] ? -tsum : tsum;
  assign slope_mag = res_slope[SL_W-1] ? -res_slope : res_slope;

  // term rounds to nearest with ties away from zero
  assign term_rnd = (term_acc + (TERM_W'(1) << (ctu_pkg::SLOPE_FRAC - 1)))
                    >> ctu_pkg::SLOPE_FRAC;
  assign term_q   = p_neg ? -B_W'(term_rnd) : B_W'(term_rnd);
  assign b_full   = B_W'($signed({1'b0, utc_ref})) + B_W'(mean_u) - term_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      dropped <= 1'b0;
      sys_ref <= '0;
      utc_ref <= '0;
      ovalid  <= 1'b0;
    end else begin
      prod_ss <= (SOFF_W + ctu_pkg::CHUNK_W)'(s_mag) * (SOFF_W + ctu_pkg::CHUNK_W)'(chunk);
      prod_au <= (MA_W + ctu_pkg::CHUNK_W)'(mul_a) * (MA_W + ctu_pkg::CHUNK_W)'(chunk);
      // the done state reloads the output register itself
      if (fits.valid && fits.ready && (state != S_DONE)) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            sys_ref <= sref;
            utc_ref <= uref;
            count   <= cnt_new;
            if (!room) begin
              dropped <= 1'b1;
            end
            if (samples.last_sample) begin
              n_fit    <= cnt_new;
              drop_fit <= dropped || !room;
              count    <= '0;
              dropped  <= 1'b0;
              if (cnt_new < CW'(2)) begin
                res_slope  <= '0;
                res_icpt   <= '0;
                res_status <= ctu_pkg::FIT_FEW;
                state      <= S_DONE;
              end else begin
                idx   <= '0;
                pend  <= 1'b0;
                sum_s <= '0;
                sum_u <= '0;
                state <= S_SUM;
              end
            end
          end
        end
        S_SUM: begin
          if (pend) begin
            sum_s <= sum_s + SUMS_W'(rd_s);
            sum_u <= sum_u + SUMU_W'(rd_u);
          end
          if (idx != n_fit) begin
            idx  <= idx + CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              dv_num <= (DW'(sums_mag) << 1) + DW'(n_fit);
              dv_den <= DW'(n_fit) << 1;
              dv_neg <= sum_s[SUMS_W-1];
              dv_rem <= '0;
              dv_q   <= '0;
              dv_cnt <= DCW'(DW);
              phase  <= PH_MEAN_S;
              state  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (dv_cnt != '0) begin
            dv_rem <= dv_ge ? rem_sh - dv_den : rem_sh;
            dv_q   <= {dv_q[DW-2:0], dv_ge};
            dv_num <= dv_num << 1;
            dv_cnt <= dv_cnt - DCW'(1);
          end else begin
            case (phase)
              PH_MEAN_S: begin
                mean_s <= MS_W'(q_signed);
                dv_num <= (DW'(sumu_mag) << 1) + DW'(n_fit);
                dv_den <= DW'(n_fit) << 1;
                dv_neg <= sum_u[SUMU_W-1];
                dv_rem <= '0;
                dv_q   <= '0;
                dv_cnt <= DCW'(DW);
                phase  <= PH_MEAN_U;
              end
              PH_MEAN_U: begin
                mean_u  <= MU_W'(q_signed);
                idx     <= '0;
                var_acc <= '0;
                cov_acc <= '0;
                state   <= S_RD;
              end
              PH_SLOPE: begin
                state <= S_SLOPE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_SUB;
        end
        S_SUB: begin
          s_mag <= ds_mag[SOFF_W-1:0];
          mul_a <= du_mag[UOFF_W-1:0];
          mul_b <= MB_W'(ds_mag[SOFF_W-1:0]);
          p_neg <= ds[SOFF_W+1] ^ du[UOFF_W+1];
          mterm <= 1'b0;
          mk    <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // the partial product of a chunk is registered and added in the next cycle
          if (mk != '0) begin
            if (mterm) begin
              term_acc <= term_acc + (TERM_W'(prod_au) << (ctu_pkg::CHUNK_W * sh));
            end else begin
              var_acc <= var_acc + (VAR_W'(prod_ss) << (ctu_pkg::CHUNK_W * sh));
              cov_acc <= p_neg ? cov_acc - (COV_W'(prod_au) << (ctu_pkg::CHUNK_W * sh))
                               : cov_acc + (COV_W'(prod_au) << (ctu_pkg::CHUNK_W * sh));
            end
          end
          if (mk == MK_W'(ctu_pkg::CHUNK_N)) begin
            if (mterm) begin
              state <= S_ICPT;
            end else if (idx == n_fit - CW'(1)) begin
              state <= S_VCHK;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_RD;
            end
          end else begin
            mk <= mk + MK_W'(1);
          end
        end
        S_VCHK: begin
          if (var_acc == '0) begin
            res_slope  <= '0;
            res_icpt   <= '0;
            res_status <= ctu_pkg::FIT_ZERO_VAR;
            state      <= S_DONE;
          end else begin
            dv_num <= (DW'(cov_mag) << (ctu_pkg::SLOPE_FRAC + 1)) + DW'(var_acc);
            dv_den <= DW'(var_acc) << 1;
            dv_neg <= cov_acc[COV_W-1];
            dv_rem <= '0;
            dv_q   <= '0;
            dv_cnt <= DCW'(DW);
            phase  <= PH_SLOPE;
            state  <= S_DIV;
          end
        end
        S_SLOPE: begin
          res_slope <= slope_sat;
          state     <= S_TSET;
        end
        S_TSET: begin
          mul_a    <= MA_W'(slope_mag);
          mul_b    <= MB_W'(tsum_mag);
          p_neg    <= res_slope[SL_W-1] ^ tsum[T_W-1];
          term_acc <= '0;
          mterm    <= 1'b1;
          mk       <= '0;
          state    <= S_MUL;
        end
        S_ICPT: begin
          if (b_full > ICPT_MAX) begin
            res_icpt <= ctu_pkg::ICPT_W'(ICPT_MAX);
          end else if (b_full < ICPT_MIN) begin
            res_icpt <= ctu_pkg::ICPT_W'(ICPT_MIN);
          end else begin
            res_icpt <= ctu_pkg::ICPT_W'(b_full);
          end
          res_status <= drop_fit ? ctu_pkg::FIT_TRUNC : ctu_pkg::FIT_OK;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!ovalid || fits.ready) begin
            o_slope  <= res_slope;
            o_icpt   <= res_icpt;
            o_status <= res_status;
            ovalid   <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign fits.valid      = ovalid;
  assign fits.slope      = o_slope;
  assign fits.intercept  = o_icpt;
  assign fits.fit_status = o_status;

  a_last_starts_fit: assert property (@(posedge clk) disable iff (rst)
    (acc_in && samples.last_sample) |=> (state != S_IDLE))
    else $error("last sample beat did not leave idle");

  a_count_clear_in_fit: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (count == '0))
    else $error("sample count not cleared during fit");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dv_rem < dv_den))
    else $error("divider remainder out of range");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(ovalid) |-> $past(state == S_DONE))
    else $error("result loaded outside the done state");
endmodule
